FILE: sv/kfd_pkg.sv
// ----------------------------------------------------------------------------
// kfd_pkg
// shared types and constants of the kiss frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package kfd_pkg;

	// field widths of one input byte and one result
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 10;
	localparam int SEL_W  = 2;
	localparam int VAL_W  = 12;
	localparam int CMD_W  = 5;
	localparam int DATA_W = BYTE_W + LEN_W + SEL_W + VAL_W;

	// default frame size limit
	localparam int MAX_FRAME_DEF = 512;

	// kiss special bytes
	localparam logic [BYTE_W-1:0] FEND  = 8'hC0;
	localparam logic [BYTE_W-1:0] FESC  = 8'hDB;
	localparam logic [BYTE_W-1:0] TFEND = 8'hDC;
	localparam logic [BYTE_W-1:0] TFESC = 8'hDD;

	// command codes, port nibble already cleared
	localparam logic [CMD_W-1:0] CMD_FRAME_DATA = 5'h00;
	localparam logic [CMD_W-1:0] CMD_TX_DELAY   = 5'h01;
	localparam logic [CMD_W-1:0] CMD_PERSIST    = 5'h02;
	localparam logic [CMD_W-1:0] CMD_SLOT       = 5'h03;
	localparam logic [CMD_W-1:0] CMD_TX_TAIL    = 5'h04;
	localparam logic [CMD_W-1:0] CMD_NONE       = 5'h10;

	// setting selectors
	localparam logic [SEL_W-1:0] SEL_TXDELAY = 2'd0;
	localparam logic [SEL_W-1:0] SEL_PERSIST = 2'd1;
	localparam logic [SEL_W-1:0] SEL_SLOT    = 2'd2;
	localparam logic [SEL_W-1:0] SEL_TXTAIL  = 2'd3;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_EOF     = 2'd1,
		KIND_SETTING = 2'd2
	} kind_t;

	// one decoded result plus its valid flag
	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0]  frame_length;
		logic [SEL_W-1:0]  setting_select;
		logic [VAL_W-1:0]  setting_value;
	} result_t;

	// byte times ten, as two shifts and an add
	function automatic logic [VAL_W-1:0] times_ten(input logic [BYTE_W-1:0] b);
		logic [VAL_W-1:0] w;
		w = {{(VAL_W-BYTE_W){1'b0}}, b};
		return (w << 3) + (w << 1);
	endfunction

endpackage

`default_nettype wire

FILE: sv/kfd_decode.sv
// ----------------------------------------------------------------------------
// kfd_decode
// kiss framing state and per-byte decode into at most one result
// ----------------------------------------------------------------------------
`default_nettype none

module kfd_decode
	import kfd_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] byte_in,
	output result_t                res
);

	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	logic             in_frame_q, in_frame_n;
	logic             esc_q, esc_n;
	logic [CMD_W-1:0] cmd_q, cmd_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic             full;
	logic [BYTE_W-1:0] unesc;
	logic [LEN_W+CNT_W-1:0] len_ext;

	assign full    = (count_q >= CNT_W'(MAX_FRAME));
	assign len_ext = {{LEN_W{1'b0}}, count_q};

	// unescape while an escape is pending
	always_comb begin
		unesc = byte_in;
		if (esc_q) begin
			if (byte_in == TFEND)
				unesc = FEND;
			else if (byte_in == TFESC)
				unesc = FESC;
		end
	end

	always_comb begin
		in_frame_n = in_frame_q;
		esc_n      = esc_q;
		cmd_n      = cmd_q;
		count_n    = count_q;
		res        = '0;
		res.kind   = KIND_DATA;
		priority if (in_frame_q && byte_in == FEND && cmd_q == CMD_FRAME_DATA) begin
			in_frame_n       = 1'b0;
			res.valid        = 1'b1;
			res.kind         = KIND_EOF;
			res.frame_length = len_ext[LEN_W-1:0];
		end else if (byte_in == FEND) begin
			in_frame_n = 1'b1;
			cmd_n      = CMD_NONE;
			count_n    = '0;
		end else if (!in_frame_q || full) begin
			// outside a frame or frame full: dropped
		end else if (count_q == '0 && cmd_q == CMD_NONE) begin
			cmd_n = {1'b0, byte_in[3:0]};
		end else begin
			unique case (cmd_q)
				CMD_FRAME_DATA: begin
					if (byte_in == FESC) begin
						esc_n = 1'b1;
					end else begin
						esc_n         = 1'b0;
						count_n       = count_q + 1'b1;
						res.valid     = 1'b1;
						res.kind      = KIND_DATA;
						res.data_byte = unesc;
					end
				end
				CMD_TX_DELAY: begin
					res.valid          = 1'b1;
					res.kind           = KIND_SETTING;
					res.setting_select = SEL_TXDELAY;
					res.setting_value  = times_ten(byte_in);
				end
				CMD_PERSIST: begin
					res.valid          = 1'b1;
					res.kind           = KIND_SETTING;
					res.setting_select = SEL_PERSIST;
					res.setting_value  = {{(VAL_W-BYTE_W){1'b0}}, byte_in};
				end
				CMD_SLOT: begin
					res.valid          = 1'b1;
					res.kind           = KIND_SETTING;
					res.setting_select = SEL_SLOT;
					res.setting_value  = times_ten(byte_in);
				end
				CMD_TX_TAIL: begin
					res.valid          = 1'b1;
					res.kind           = KIND_SETTING;
					res.setting_select = SEL_TXTAIL;
					res.setting_value  = times_ten(byte_in);
				end
				default: begin
					// unused command: ignored
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			cmd_q      <= CMD_NONE;
			count_q    <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_n;
			esc_q      <= esc_n;
			cmd_q      <= cmd_n;
			count_q    <= count_n;
		end
	end

	// count never runs past the frame limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME))
		else $error("byte count beyond frame limit");

	// only data frames count bytes
	a_count_data_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q != CMD_FRAME_DATA |-> count_q == '0)
		else $error("byte count in a non-data frame");

	// end of frame closes the frame
	a_eof_closes: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.kind == KIND_EOF |=> !in_frame_q)
		else $error("frame still open after end of frame");

endmodule

`default_nettype wire

FILE: sv/kfd_out_reg.sv
// ----------------------------------------------------------------------------
// kfd_out_reg
// result register driving the master stream side
// ----------------------------------------------------------------------------
`default_nettype none

module kfd_out_reg
	import kfd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire result_t           res,
	output logic                   room,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [DATA_W-1:0]      m_axis_tdata,
	output logic [1:0]             m_axis_tuser
);

	logic    valid_q;
	result_t res_q;

	assign room = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tdata  = {res_q.setting_value, res_q.setting_select,
	                        res_q.frame_length, res_q.data_byte};

	// fields that do not belong to the kind read as zero
	a_eof_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.kind == KIND_EOF |-> res_q.data_byte == '0
			&& res_q.setting_value == '0)
		else $error("stray fields on end of frame");

	a_setting_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.kind == KIND_SETTING |-> res_q.frame_length == '0
			&& res_q.data_byte == '0)
		else $error("stray fields on setting update");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.kind == KIND_DATA |-> res_q.setting_value == '0
			&& res_q.frame_length == '0)
		else $error("stray fields on data byte");

endmodule

`default_nettype wire

FILE: sv/kiss_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// kiss_frame_deframer_core
// streaming kiss decoder: one received byte in, at most one result out
// ----------------------------------------------------------------------------
// Takes the kiss byte stream one byte per cycle and emits data bytes, end of
// frame markers with the byte count, and setting updates. Each byte passes
// an input register, then the decode logic against the framing state, then
// the result register, which takes the result when its byte is decoded; a
// new byte is taken every cycle as long as the result register has room
// (bytes that give no result never wait on it). The framing state (in
// frame, escape pending, command, byte count) advances once per decoded
// byte, which sets the rate at one byte per cycle. Bytes beyond MAX_FRAME
// in a data frame are dropped, the closing FEND still reports the count
// (as 10 bits). The escape flag is kept across frames.
// tuser carries the result kind: 0 data byte, 1 end of frame, 2 setting.
// ----------------------------------------------------------------------------
`default_nettype none

module kiss_frame_deframer_core
	import kfd_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF  // data bytes kept per frame, 16 to 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input stream
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] byte_in
	// result stream
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [DATA_W-1:0]      m_axis_tdata,   // [7:0] data_byte, [17:8] frame_length,
	                                               // [19:18] setting_select,
	                                               // [31:20] setting_value
	output logic [1:0]             m_axis_tuser    // [1:0] kind
);

	// input register
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;

	// decode handshake
	result_t res;
	logic    room;   // result register can take a result this cycle
	logic    step;   // byte in s1 is decoded and leaves

	assign step          = v_s1 && (!res.valid || room);
	assign s_axis_tready = !v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// framing state and per-byte decode
	kfd_decode #(
		.MAX_FRAME(MAX_FRAME)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.byte_in(byte_s1),
		.res    (res)
	);

	// result register
	kfd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step && res.valid),
		.res          (res),
		.room         (room),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// a byte that gives a result only leaves when the result register has room
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready && v_s1 && res.valid |-> !step)
		else $error("result lost while output stalled");

	// a held byte blocks the input until it is decoded
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !step |-> !s_axis_tready)
		else $error("input taken over an undecoded byte");

	// the input register only empties by decoding
	a_s1_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !step |=> v_s1 && $stable(byte_s1))
		else $error("undecoded byte dropped");

endmodule

`default_nettype wire
